### rtl/core/grid_dda_raycast_column_assert.svh
// Assertion macros shared by the ray caster checker.
`ifndef GRID_DDA_RAYCAST_COLUMN_ASSERT_SVH
`define GRID_DDA_RAYCAST_COLUMN_ASSERT_SVH

// Implication in the same cycle.
`define GDRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define GDRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gdrc_pkg.sv
// Types and constants of the column ray caster.
`default_nettype none
package gdrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAP_BITS  = 6;
  localparam int MAP_DIM   = 1 << MAP_BITS;
  localparam int ADDR_W    = 2 * MAP_BITS;
  localparam int MAX_STEPS = 128;
  localparam int STEP_W    = 8;
  localparam int TEX_BITS  = 6;
  localparam int LEN_W     = 46;
  localparam int NUM_W     = 33;
  localparam int DEN_W     = 34;
  localparam int CNT_W     = 6;
  localparam int PERP_W    = 24;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    CFG_PLAYER_X      = 4'd0,
    CFG_PLAYER_Y      = 4'd1,
    CFG_DIR_X         = 4'd2,
    CFG_DIR_Y         = 4'd3,
    CFG_PLANE_X       = 4'd4,
    CFG_PLANE_Y       = 4'd5,
    CFG_SCREEN_WIDTH  = 4'd6,
    CFG_SCREEN_HEIGHT = 4'd7
  } cfg_idx_t;

  // Request kinds.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_CAM, S_RX, S_RY, S_RYW, S_UX, S_UY,
    S_LX0, S_LX1, S_LX2, S_LY1, S_LY2,
    S_STEP, S_READ, S_PERP, S_TEX, S_TEXW, S_LHW
  } state_t;

endpackage
`default_nettype wire

### rtl/core/gdrc_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module gdrc_div (
  input  wire                 clk,
  input  wire                 rst,
  input  gdrc_pkg::div_req_t  req,
  output gdrc_pkg::div_rsp_t  rsp
);

  logic                           run;
  logic [gdrc_pkg::CNT_W-1:0]     cnt;
  logic [gdrc_pkg::DEN_W-1:0]     rem;
  logic [gdrc_pkg::NUM_W-1:0]     dvd;
  logic [gdrc_pkg::DEN_W-1:0]     den;
  logic                           done;
  logic [gdrc_pkg::DEN_W:0]       rem_sh;
  logic                           fits;

  // Trial subtraction of one step.
  always_comb begin
    rem_sh = {rem, dvd[gdrc_pkg::NUM_W-1]};
    fits   = rem_sh >= {1'b0, den};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      run  <= 1'b1;
      done <= 1'b0;
      cnt  <= gdrc_pkg::CNT_W'(gdrc_pkg::NUM_W);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == gdrc_pkg::CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: the dividend register fills with quotient bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.num;
      den <= req.den;
    end else if (run) begin
      rem <= fits ? gdrc_pkg::DEN_W'(rem_sh - {1'b0, den}) : rem_sh[gdrc_pkg::DEN_W-1:0];
      dvd <= {dvd[gdrc_pkg::NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;

endmodule
`default_nettype wire

### rtl/core/gdrc_map.sv
// Cell map memory with one write port and a registered read port.
`default_nettype none
module gdrc_map (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [gdrc_pkg::ADDR_W-1:0]   wr_addr,
  input  wire [7:0]                    wr_data,
  input  wire                          rd_en,
  input  wire [gdrc_pkg::ADDR_W-1:0]   rd_addr,
  output logic [7:0]                   rd_data
);

  logic [7:0] mem [gdrc_pkg::MAP_DIM*gdrc_pkg::MAP_DIM];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered: data follows in the cycle after the read enable.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/grid_dda_raycast_column.sv
// Top level of the column ray caster: sequencer, arithmetic and result registers.
//
// A request is taken when start is high and busy is low. A write request
// (action 0) stores cell_value at cell_x, cell_y and gives no
// result; busy stays low. A cast request (action 1) raises busy and walks
// the map for the given column, then shows one result for exactly one cycle
// with done high, the cycle in which busy has fallen again.
// A cast runs four divisions on the shared one-bit-per-cycle divider
// (camera offset, two unit steps, wall height) besides setup and
// multiplies, and walks the map cell by cell, each step waiting for the
// map read. A cast ends early as a miss at the step limit of 128 cells
// or when the player is outside the map.
// The next request can be taken in the cycle that shows the result.
// Configuration writes are taken at any time (cfg_ready is always high)
// and must only be issued while the block is idle.
// Reset restores the register defaults and drops done; the map is not
// cleared, and a cell must be written before a walk reads it.
// The receiver cannot stall: each result is flagged by done for one cycle.
`default_nettype none
module grid_dda_raycast_column (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  output logic              busy,
  input  wire               action,
  input  wire  [5:0]        cell_x,
  input  wire  [5:0]        cell_y,
  input  wire  [7:0]        cell_value,
  input  wire  [11:0]       column,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [3:0]        cfg_index,
  input  wire  [21:0]       cfg_data,
  output logic              done,
  output logic [11:0]       column_out,
  output logic              hit,
  output logic              side,
  output logic [7:0]        wall_type,
  output logic [5:0]        hit_x,
  output logic [5:0]        hit_y,
  output logic [23:0]       perp_distance,
  output logic [11:0]       line_height,
  output logic signed [11:0] draw_start,
  output logic [5:0]        tex_column,
  output logic [7:0]        fade
);

  localparam int FB = gdrc_pkg::FRAC_BITS;
  localparam int LW = gdrc_pkg::LEN_W;

  // Configuration registers.
  logic [21:0]        player_x, player_y;
  logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
  logic [12:0]        screen_width, screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= 22'd98304;
      player_y      <= 22'd98304;
      dir_x         <= 18'sd65536;
      dir_y         <= 18'sd0;
      plane_x       <= 18'sd0;
      plane_y       <= 18'sd43254;
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (gdrc_pkg::cfg_idx_t'(cfg_index))
        gdrc_pkg::CFG_PLAYER_X:      player_x      <= cfg_data;
        gdrc_pkg::CFG_PLAYER_Y:      player_y      <= cfg_data;
        gdrc_pkg::CFG_DIR_X:         dir_x         <= cfg_data[17:0];
        gdrc_pkg::CFG_DIR_Y:         dir_y         <= cfg_data[17:0];
        gdrc_pkg::CFG_PLANE_X:       plane_x       <= cfg_data[17:0];
        gdrc_pkg::CFG_PLANE_Y:       plane_y       <= cfg_data[17:0];
        gdrc_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        gdrc_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  gdrc_pkg::state_t state, state_next;

  // Working registers.
  logic [11:0]               col;
  logic signed [30:0]        cam;
  logic signed [33:0]        rdx, rdy;
  logic [36:0]               ux, uy;
  logic [LW-1:0]             lx, ly, walk_len;
  logic [37:0]               acc;
  logic signed [7:0]         mx, my;
  logic [gdrc_pkg::STEP_W-1:0] steps;
  logic                      sd;
  logic [7:0]                code;
  logic [23:0]               perp;
  logic [5:0]                tex;
  logic signed [66:0]        mul_p;

  // Combinational helpers.
  logic signed [34:0]        mul_a;
  logic signed [31:0]        mul_b;
  logic [33:0]               abs_rx, abs_ry, abs_t;
  logic [16:0]               dx, dy;
  logic signed [32:0]        prod_t;
  logic signed [7:0]         nmx, nmy;
  logic                      move_x, out_map;
  logic [54:0]               len_sum;
  logic [12:0]               sw;
  logic [15:0]               tq, inter;
  logic [11:0]               lh;
  logic signed [13:0]        ds;
  logic [28:0]               sub20;
  logic [28:0]               fade_full;
  logic                      finish_miss, finish_hit, cast_go, write_go;

  gdrc_pkg::div_req_t div_req;
  gdrc_pkg::div_rsp_t div_rsp;
  logic [7:0]         rd_data;
  logic               rd_en;

  assign busy     = (state != gdrc_pkg::S_IDLE);
  assign cast_go  = start && !busy && (action == gdrc_pkg::ACT_CAST);
  assign write_go = start && !busy && (action == gdrc_pkg::ACT_WRITE);

  // Derived values.
  always_comb begin
    abs_rx  = rdx[33] ? 34'(-rdx) : 34'(rdx);
    abs_ry  = rdy[33] ? 34'(-rdy) : 34'(rdy);
    dx      = rdx[33] ? {1'b0, player_x[15:0]} : 17'h10000 - {1'b0, player_x[15:0]};
    dy      = rdy[33] ? {1'b0, player_y[15:0]} : 17'h10000 - {1'b0, player_y[15:0]};
    // Product divided by one, rounded toward zero.
    prod_t  = mul_p[66] ? 33'((mul_p + 67'sd65535) >>> FB) : 33'(mul_p >>> FB);
    len_sum = 55'(acc) + (55'(mul_p[33:0]) << 20);
    sw      = (screen_width == 13'd0) ? 13'd1 : screen_width;
    move_x  = lx < ly;
    nmx     = move_x ? (rdx[33] ? mx - 8'sd1 : mx + 8'sd1) : mx;
    nmy     = move_x ? my : (rdy[33] ? my - 8'sd1 : my + 8'sd1);
    out_map = (nmx < 8'sd0) || (nmx >= 8'(gdrc_pkg::MAP_DIM)) ||
              (nmy < 8'sd0) || (nmy >= 8'(gdrc_pkg::MAP_DIM));
    abs_t   = sd ? abs_rx : abs_ry;
    tq      = (sd ? rdx[33] : rdy[33]) ? 16'(-mul_p[31:16]) : mul_p[31:16];
    inter   = (sd ? player_x[15:0] : player_y[15:0]) + tq;
    lh      = (perp == 24'd0 || div_rsp.quot > 33'd4095) ? 12'd4095 : div_rsp.quot[11:0];
    ds      = 14'(screen_height[12:1]) - 14'(lh[11:1]);
    sub20   = (29'(perp) << 4) + (29'(perp) << 2);
    fade_full = 29'(255) << FB;
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      gdrc_pkg::S_RX:  begin mul_a = 35'(plane_x); mul_b = 32'(cam); end
      gdrc_pkg::S_RY:  begin mul_a = 35'(plane_y); mul_b = 32'(cam); end
      gdrc_pkg::S_LX0: begin mul_a = 35'(dx); mul_b = 32'(ux[19:0]); end
      gdrc_pkg::S_LX1: begin mul_a = 35'(dx); mul_b = 32'(ux[36:20]); end
      gdrc_pkg::S_LX2: begin mul_a = 35'(dy); mul_b = 32'(uy[19:0]); end
      gdrc_pkg::S_LY1: begin mul_a = 35'(dy); mul_b = 32'(uy[36:20]); end
      gdrc_pkg::S_TEX: begin mul_a = 35'(abs_t[31:0]); mul_b = 32'(perp); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Divider requests.
  always_comb begin
    div_req = '0;
    if (cast_go) begin
      div_req.start = 1'b1;
      div_req.num   = 33'({column, 1'b0}) << FB;
      div_req.den   = 34'(sw);
    end else if (state == gdrc_pkg::S_RYW) begin
      div_req.start = 1'b1;
      div_req.num   = 33'h1_0000_0000;
      div_req.den   = abs_rx;
    end else if (state == gdrc_pkg::S_UX && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = 33'h1_0000_0000;
      div_req.den   = abs_ry;
    end else if (state == gdrc_pkg::S_TEXW) begin
      div_req.start = 1'b1;
      div_req.num   = 33'(1000) << FB;
      div_req.den   = 34'(perp);
    end
  end

  // Next state.
  always_comb begin
    state_next  = state;
    finish_miss = 1'b0;
    finish_hit  = 1'b0;
    rd_en       = 1'b0;
    unique case (state)
      gdrc_pkg::S_IDLE: if (cast_go) state_next = gdrc_pkg::S_CAM;
      gdrc_pkg::S_CAM:  if (div_rsp.done) state_next = gdrc_pkg::S_RX;
      gdrc_pkg::S_RX:   state_next = gdrc_pkg::S_RY;
      gdrc_pkg::S_RY:   state_next = gdrc_pkg::S_RYW;
      gdrc_pkg::S_RYW: begin
        if ({2'b0, player_x[21:16]} >= 8'(gdrc_pkg::MAP_DIM) ||
            {2'b0, player_y[21:16]} >= 8'(gdrc_pkg::MAP_DIM)) begin
          finish_miss = 1'b1;
          state_next  = gdrc_pkg::S_IDLE;
        end else begin
          state_next = gdrc_pkg::S_UX;
        end
      end
      gdrc_pkg::S_UX:   if (div_rsp.done) state_next = gdrc_pkg::S_UY;
      gdrc_pkg::S_UY:   if (div_rsp.done) state_next = gdrc_pkg::S_LX0;
      gdrc_pkg::S_LX0:  state_next = gdrc_pkg::S_LX1;
      gdrc_pkg::S_LX1:  state_next = gdrc_pkg::S_LX2;
      gdrc_pkg::S_LX2:  state_next = gdrc_pkg::S_LY1;
      gdrc_pkg::S_LY1:  state_next = gdrc_pkg::S_LY2;
      gdrc_pkg::S_LY2:  state_next = gdrc_pkg::S_STEP;
      gdrc_pkg::S_STEP: begin
        if (steps == gdrc_pkg::STEP_W'(gdrc_pkg::MAX_STEPS) || out_map) begin
          finish_miss = 1'b1;
          state_next  = gdrc_pkg::S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = gdrc_pkg::S_READ;
        end
      end
      gdrc_pkg::S_READ: state_next = (rd_data != 8'd0) ? gdrc_pkg::S_PERP : gdrc_pkg::S_STEP;
      gdrc_pkg::S_PERP: state_next = gdrc_pkg::S_TEX;
      gdrc_pkg::S_TEX:  state_next = gdrc_pkg::S_TEXW;
      gdrc_pkg::S_TEXW: state_next = gdrc_pkg::S_LHW;
      gdrc_pkg::S_LHW: begin
        if (div_rsp.done) begin
          finish_hit = 1'b1;
          state_next = gdrc_pkg::S_IDLE;
        end
      end
      default: state_next = gdrc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdrc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      gdrc_pkg::S_IDLE: if (cast_go) col <= column;
      gdrc_pkg::S_CAM:  cam <= 31'(div_rsp.quot[29:0]) - 31'sd65536;
      gdrc_pkg::S_RY:   rdx <= 34'(dir_x) + 34'(prod_t);
      gdrc_pkg::S_RYW: begin
        rdy <= 34'(dir_y) + 34'(prod_t);
        mx  <= 8'({2'b0, player_x[21:16]});
        my  <= 8'({2'b0, player_y[21:16]});
      end
      gdrc_pkg::S_UX:
        if (div_rsp.done) ux <= (rdx == 34'sd0) ? 37'h10_0000_0000 : 37'(div_rsp.quot);
      gdrc_pkg::S_UY:
        if (div_rsp.done) uy <= (rdy == 34'sd0) ? 37'h10_0000_0000 : 37'(div_rsp.quot);
      gdrc_pkg::S_LX1: acc <= mul_p[37:0];
      gdrc_pkg::S_LX2: lx  <= LW'(len_sum >> FB);
      gdrc_pkg::S_LY1: acc <= mul_p[37:0];
      gdrc_pkg::S_LY2: begin
        ly    <= LW'(len_sum >> FB);
        steps <= '0;
      end
      gdrc_pkg::S_STEP: begin
        steps <= steps + 1'b1;
        mx    <= nmx;
        my    <= nmy;
        sd    <= !move_x;
        if (move_x) begin
          walk_len <= lx;
          lx       <= lx + LW'(ux);
        end else begin
          walk_len <= ly;
          ly       <= ly + LW'(uy);
        end
      end
      gdrc_pkg::S_READ: code <= rd_data;
      gdrc_pkg::S_PERP: perp <= (walk_len > LW'(24'hFF_FFFF)) ? 24'hFF_FFFF : walk_len[23:0];
      gdrc_pkg::S_TEXW: tex <= inter[FB-1 -: gdrc_pkg::TEX_BITS];
      default: ;
    endcase
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (finish_miss || finish_hit) begin
      column_out    <= col;
      hit           <= finish_hit;
      side          <= finish_hit && sd;
      wall_type     <= finish_hit ? code : 8'd0;
      hit_x         <= finish_hit ? mx[5:0] : 6'd0;
      hit_y         <= finish_hit ? my[5:0] : 6'd0;
      perp_distance <= finish_hit ? perp : 24'd0;
      line_height   <= finish_hit ? lh : 12'd0;
      draw_start    <= !finish_hit ? 12'sd0 :
                       (ds > 14'sd2047) ? 12'sd2047 :
                       (ds < -14'sd2048) ? -12'sd2048 : 12'(ds);
      tex_column    <= finish_hit ? tex : 6'd0;
      fade          <= (!finish_hit || sub20 >= fade_full) ? 8'd0 :
                       8'((fade_full - sub20) >> FB);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish_miss || finish_hit;
    end
  end

  gdrc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  gdrc_map u_map (
    .clk     (clk),
    .wr_en   (write_go),
    .wr_addr ({cell_y, cell_x}),
    .wr_data (cell_value),
    .rd_en   (rd_en),
    .rd_addr ({nmy[5:0], nmx[5:0]}),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

### rtl/core/gdrc_checker.sv
// Port checker of the column ray caster and its bind to the top level.
`default_nettype none
`include "grid_dda_raycast_column_assert.svh"
module gdrc_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        action,
  input wire        done,
  input wire        hit,
  input wire [23:0] perp_distance,
  input wire [11:0] line_height,
  input wire [7:0]  fade
);

  `GDRC_ASSERT_NEXT(a_cast_busy, start && !busy && action, busy, "cast request did not raise busy")
  `GDRC_ASSERT_NEXT(a_write_quick, start && !busy && !action, !busy, "write request raised busy")
  `GDRC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")
  `GDRC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `GDRC_ASSERT_NOW(a_miss_zero, done && !hit, perp_distance == 24'd0 && line_height == 12'd0 && fade == 8'd0, "miss result carries data")

endmodule

bind grid_dda_raycast_column gdrc_checker u_gdrc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .action        (action),
  .done          (done),
  .hit           (hit),
  .perp_distance (perp_distance),
  .line_height   (line_height),
  .fade          (fade)
);
`default_nettype wire

### test/grid_dda_raycast_column_check.sv
// Checker for the column ray caster: tracks map and registers, predicts and compares casts.
module grid_dda_raycast_column_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               action,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  input  logic [7:0]         cell_value,
  input  logic [11:0]        column,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  input  logic               done,
  input  logic [11:0]        column_out,
  input  logic               hit,
  input  logic               side,
  input  logic [7:0]         wall_type,
  input  logic [5:0]         hit_x,
  input  logic [5:0]         hit_y,
  input  logic [23:0]        perp_distance,
  input  logic [11:0]        line_height,
  input  logic signed [11:0] draw_start,
  input  logic [5:0]         tex_column,
  input  logic [7:0]         fade,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [11:0] column_out;
    logic        hit;
    logic        side;
    logic [7:0]  wall_type;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [23:0] perp_distance;
    logic [11:0] line_height;
    logic [11:0] draw_start;
    logic [5:0]  tex_column;
    logic [7:0]  fade;
  } column_hit_t;

  localparam int FB = gdrc_pkg::FRAC_BITS;
  localparam int DIM = gdrc_pkg::MAP_DIM;
  localparam longint ONE = longint'(1) << FB;
  localparam longint unsigned STEP_LIMIT = longint'(1) << 36;
  localparam longint unsigned PERP_LIMIT = 64'hFF_FFFF;

  logic [7:0]         cells [DIM*DIM];
  logic [21:0]        pos_x, pos_y;
  logic signed [17:0] view_x, view_y, cam_x, cam_y;
  logic [12:0]        scr_w, scr_h;
  column_hit_t        hits_due [$];

  // Length along the ray between two grid lines of one axis.
  function automatic longint unsigned axis_step(longint r);
    longint unsigned a, d;
    if (r == 0) return STEP_LIMIT;
    a = (r < 0) ? -r : r;
    d = (longint'(1) << (2 * FB)) / a;
    return (d > STEP_LIMIT) ? STEP_LIMIT : d;
  endfunction

  // Walk the grid for one screen column and form the wall column.
  function automatic column_hit_t trace_column(logic [11:0] col);
    column_hit_t r;
    longint sw, cam, rx, ry, px, py, mx, my, inter, ds;
    longint unsigned ux, uy, lx, ly, walk_len, perp, lh, frac, sub, full;
    int sx, sy;
    bit crossed_y, found;
    logic [7:0] code;
    r = '0;
    r.column_out = col;
    walk_len = 0;
    crossed_y = 0;
    found = 0;
    code = '0;
    sw = (scr_w == 0) ? 1 : longint'(scr_w);
    cam = ((longint'(col) * 2) <<< FB) / sw - ONE;
    rx = longint'(view_x) + (longint'(cam_x) * cam) / ONE;
    ry = longint'(view_y) + (longint'(cam_y) * cam) / ONE;
    px = longint'(pos_x);
    py = longint'(pos_y);
    mx = px >>> FB;
    my = py >>> FB;
    if (mx >= DIM || my >= DIM) return r;
    ux = axis_step(rx);
    uy = axis_step(ry);
    if (rx < 0) begin
      sx = -1;
      lx = (longint'(px - mx * ONE) * ux) >> FB;
    end else begin
      sx = 1;
      lx = (longint'((mx + 1) * ONE - px) * ux) >> FB;
    end
    if (ry < 0) begin
      sy = -1;
      ly = (longint'(py - my * ONE) * uy) >> FB;
    end else begin
      sy = 1;
      ly = (longint'((my + 1) * ONE - py) * uy) >> FB;
    end
    for (int n = 0; n < gdrc_pkg::MAX_STEPS; n++) begin
      if (lx < ly) begin
        mx += sx;
        walk_len = lx;
        lx += ux;
        crossed_y = 0;
      end else begin
        my += sy;
        walk_len = ly;
        ly += uy;
        crossed_y = 1;
      end
      if (mx < 0 || mx >= DIM || my < 0 || my >= DIM) return r;
      code = cells[my * DIM + mx];
      if (code != 0) begin
        found = 1;
        break;
      end
    end
    if (!found) return r;

    // Wall column height, top row, texture column and fade.
    perp = (walk_len > PERP_LIMIT) ? PERP_LIMIT : walk_len;
    if (perp == 0) lh = 4095;
    else begin
      lh = (longint'(1000) << FB) / perp;
      if (lh > 4095) lh = 4095;
    end
    ds = longint'(scr_h / 2) - longint'(lh / 2);
    if (ds > 2047) ds = 2047;
    if (ds < -2048) ds = -2048;
    if (!crossed_y) inter = py + (ry * longint'(perp)) / ONE;
    else inter = px + (rx * longint'(perp)) / ONE;
    frac = inter & (ONE - 1);
    full = longint'(255) << FB;
    sub = 20 * perp;
    r.hit = 1'b1;
    r.side = crossed_y;
    r.wall_type = code;
    r.hit_x = mx[5:0];
    r.hit_y = my[5:0];
    r.perp_distance = perp[23:0];
    r.line_height = lh[11:0];
    r.draw_start = ds[11:0];
    r.tex_column = 6'((frac * 64) >> FB);
    r.fade = (sub >= full) ? 8'd0 : 8'((full - sub) >> FB);
    return r;
  endfunction

  // Compare results first, then take in requests and register writes of this edge.
  always @(posedge clk) begin
    column_hit_t got, want;
    if (rst) begin
      pos_x <= 22'd98304;
      pos_y <= 22'd98304;
      view_x <= 18'sd65536;
      view_y <= 18'sd0;
      cam_x <= 18'sd0;
      cam_y <= 18'sd43254;
      scr_w <= 13'd640;
      scr_h <= 13'd480;
      hits_due.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        got = '{column_out, hit, side, wall_type, hit_x, hit_y, perp_distance,
                line_height, draw_start, tex_column, fade};
        if (hits_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result for column %0d", column_out);
        end else begin
          want = hits_due.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display({"col %0d: expected hit %0d side %0d type %0d cell %0d,%0d ",
                        "dist %0h lh %0d top %0d tex %0d fade %0d; got hit %0d side %0d ",
                        "type %0d cell %0d,%0d dist %0h lh %0d top %0d tex %0d fade %0d"},
                       want.column_out, want.hit, want.side, want.wall_type, want.hit_x,
                       want.hit_y, want.perp_distance, want.line_height,
                       $signed(want.draw_start), want.tex_column, want.fade,
                       got.hit, got.side, got.wall_type, got.hit_x, got.hit_y,
                       got.perp_distance, got.line_height, $signed(got.draw_start),
                       got.tex_column, got.fade);
          end
        end
      end
      if (start && !busy) begin
        if (action == gdrc_pkg::ACT_WRITE) cells[{cell_y, cell_x}] = cell_value;
        else hits_due.push_back(trace_column(column));
      end
      pending <= hits_due.size();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gdrc_pkg::CFG_PLAYER_X:      pos_x <= cfg_data;
          gdrc_pkg::CFG_PLAYER_Y:      pos_y <= cfg_data;
          gdrc_pkg::CFG_DIR_X:         view_x <= cfg_data[17:0];
          gdrc_pkg::CFG_DIR_Y:         view_y <= cfg_data[17:0];
          gdrc_pkg::CFG_PLANE_X:       cam_x <= cfg_data[17:0];
          gdrc_pkg::CFG_PLANE_Y:       cam_y <= cfg_data[17:0];
          gdrc_pkg::CFG_SCREEN_WIDTH:  scr_w <= cfg_data[12:0];
          gdrc_pkg::CFG_SCREEN_HEIGHT: scr_h <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### test/grid_dda_raycast_column_tb.sv
// Testbench top for the column ray caster: map load, view settings and random casts.
module grid_dda_raycast_column_tb;

  localparam logic [3:0] CFG_SPARE = 4'd12;
  // Walks stay inside this square corner of the map; its far row and column are walls.
  localparam int AREA = 16;

  logic clk, rst, start, action, cfg_valid;
  logic [5:0] cell_x, cell_y;
  logic [7:0] cell_value;
  logic [11:0] column;
  logic [3:0] cfg_index;
  logic [21:0] cfg_data;
  logic busy, cfg_ready, done, hit, side;
  logic [11:0] column_out, line_height;
  logic signed [11:0] draw_start;
  logic [7:0] wall_type, fade;
  logic [5:0] hit_x, hit_y, tex_column;
  logic [23:0] perp_distance;
  int errors, pending;
  int unsigned cur_width;
  bit quiet;

  grid_dda_raycast_column dut (.*);
  grid_dda_raycast_column_check check (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(logic act, logic [5:0] x, logic [5:0] y,
                              logic [7:0] v, logic [11:0] col);
    @(negedge clk);
    action = act; cell_x = x; cell_y = y; cell_value = v; column = col;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random idle time after a request: mostly none, sometimes short, rarely long.
  task automatic idle_gap();
    int g;
    g = 0;
    if (!quiet && $urandom_range(0, 9) >= 6)
      g = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every cast has reported and the block is quiet.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (450) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [21:0] val);
    @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load a full view setting; signed fields go as 18-bit patterns.
  task automatic set_view(int px, int py, int dx, int dy, int plx, int ply,
                          int sw, int sh);
    write_reg(gdrc_pkg::CFG_PLAYER_X, px[21:0]);
    write_reg(gdrc_pkg::CFG_PLAYER_Y, py[21:0]);
    write_reg(gdrc_pkg::CFG_DIR_X, {4'd0, dx[17:0]});
    write_reg(gdrc_pkg::CFG_DIR_Y, {4'd0, dy[17:0]});
    write_reg(gdrc_pkg::CFG_PLANE_X, {4'd0, plx[17:0]});
    write_reg(gdrc_pkg::CFG_PLANE_Y, {4'd0, ply[17:0]});
    write_reg(gdrc_pkg::CFG_SCREEN_WIDTH, sw[21:0]);
    write_reg(gdrc_pkg::CFG_SCREEN_HEIGHT, sh[21:0]);
    cur_width = sw;
  endtask

  task automatic cast(logic [11:0] col);
    send_request(gdrc_pkg::ACT_CAST, 6'($urandom), 6'($urandom), 8'($urandom), col);
    idle_gap();
  endtask

  // Random mix of casts and map edits inside the walled area; the walls stay.
  task automatic random_items(int count);
    logic [7:0] v;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        cast(12'($urandom_range(0, cur_width - 1)));
      end else begin
        v = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(1, 255));
        send_request(gdrc_pkg::ACT_WRITE, 6'($urandom_range(0, AREA - 2)),
                     6'($urandom_range(0, AREA - 2)), v, 12'($urandom));
        idle_gap();
      end
    end
  endtask

  initial begin
    int sw;
    start = 0; action = 0; cell_x = 0; cell_y = 0; cell_value = 0; column = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    cur_width = 640; quiet = 1;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every cell a walk can reach is written first: walled far edges, sparse inner walls.
    for (int y = 0; y < AREA; y++)
      for (int x = 0; x < AREA; x++)
        send_request(gdrc_pkg::ACT_WRITE, 6'(x), 6'(y),
                     (x == AREA - 1 || y == AREA - 1 ||
                      $urandom_range(0, 99) < 10) ? 8'($urandom_range(1, 255)) : 8'd0,
                     12'($urandom));

    // Directed: defaults, corner codes, a wall right beside the player.
    send_request(gdrc_pkg::ACT_WRITE, 0, 0, 8'd255, 0);
    send_request(gdrc_pkg::ACT_WRITE, 63, 63, 8'd1, 0);
    send_request(gdrc_pkg::ACT_WRITE, 62, 63, 8'd7, 0);
    send_request(gdrc_pkg::ACT_WRITE, 63, 62, 8'd9, 0);
    send_request(gdrc_pkg::ACT_WRITE, 2, 1, 8'd200, 0);
    cast(0); cast(639); cast(320);
    send_request(gdrc_pkg::ACT_WRITE, 2, 1, 8'd0, 0);
    cast(320); cast(100);
    drain();

    // Register extremes, position on the map corners.
    set_view(0, 0, -131072, 131071, -131072, 0, 2, 2);
    write_reg(CFG_SPARE, 22'h3F_FFFF);
    cast(0); cast(1);
    drain();
    set_view(4194303, 4194303, 131071, -131072, 131071, -131072, 4096, 4096);
    cast(0); cast(4095); cast(2048); cast(1365);
    drain();
    // Player on a grid line looking back along it: zero distance.
    set_view(32'h2_0000, 32'h2_8000, -65536, 0, 0, 43254, 640, 480);
    cast(320); cast(0);
    drain();
    // One ray axis exactly zero, then a nearly axis-parallel ray for a far wall.
    set_view(32'h1_8000, 32'h1_8000, 0, 65536, 0, 0, 640, 480);
    cast(5); cast(600);
    drain();
    set_view(32'h1_8000, 32'h1_8000, 1, 0, 0, 0, 640, 480);
    cast(7); cast(300);
    drain();

    // Random phases; the sender pauses for every result at each change.
    for (int p = 0; p < 10; p++) begin
      quiet = (p % 4 == 3);
      sw = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4096) : $urandom_range(64, 1024);
      set_view($urandom_range(1 << 16, ((AREA - 1) << 16) - 1),
               $urandom_range(1 << 16, ((AREA - 1) << 16) - 1),
               $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
               $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
               sw, $urandom_range(2, 4096));
      random_items(48);
      drain();
    end

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
